// File: rtl/mcwd_pkg.sv
package mcwd_pkg;

	localparam int CHANNELS   = 16;
	localparam int COUNT_BITS = 16;
	localparam int CH_BITS    = 4;
	localparam int TMO_BITS   = 16;
	localparam int IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	// only the first 16 channels are reachable through the channel field
	localparam int SCAN_N     = (CHANNELS < 16) ? CHANNELS : 16;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [COUNT_BITS-1:0] cnt_t;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_REG   = 2'd1,
		ACT_UNREG = 2'd2,
		ACT_FEED  = 2'd3
	} action_t;

	localparam logic KIND_EXPIRED = 1'b0;
	localparam logic KIND_NOREG   = 1'b1;

	// sequencer -> channel table
	typedef struct packed {
		idx_t rd_idx;
		idx_t wr_idx;
		logic set_vld;
		logic clr_vld;
		logic wr_load;
		logic wr_dec;
		logic wr_reload;
		cnt_t load_val;
	} tbl_ctl_t;

	// channel table -> sequencer
	typedef struct packed {
		logic vld;
		logic rem_zero;
	} tbl_sts_t;

	function automatic idx_t to_idx(input logic [CH_BITS-1:0] ch);
		logic [IDX_W+CH_BITS-1:0] t;
		t = {{IDX_W{1'b0}}, ch};
		return t[IDX_W-1:0];
	endfunction

	function automatic logic [CH_BITS-1:0] to_ch(input idx_t idx);
		logic [IDX_W+CH_BITS-1:0] t;
		t = {{CH_BITS{1'b0}}, idx};
		return t[CH_BITS-1:0];
	endfunction

	function automatic cnt_t to_cnt(input logic [TMO_BITS-1:0] v);
		logic [COUNT_BITS+TMO_BITS-1:0] t;
		t = {{COUNT_BITS{1'b0}}, v};
		return t[COUNT_BITS-1:0];
	endfunction

endpackage

// File: rtl/mcwd_table.sv
module mcwd_table
	import mcwd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  tbl_ctl_t ctl,
	output tbl_sts_t sts
);

	logic [CHANNELS-1:0] valid_q;
	cnt_t tmo_mem [CHANNELS];
	cnt_t rem_mem [CHANNELS];
	cnt_t tmo_rd_q;
	cnt_t rem_rd_q;
	logic vld_rd_q;
	cnt_t rem_dec;

	// shared decrement / zero-test unit
	assign rem_dec      = rem_rd_q - cnt_t'(1);
	assign sts.rem_zero = (rem_rd_q == '0);
	assign sts.vld      = vld_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			vld_rd_q <= valid_q[ctl.rd_idx];
			if (ctl.set_vld)
				valid_q[ctl.wr_idx] <= 1'b1;
			else if (ctl.clr_vld)
				valid_q[ctl.wr_idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		tmo_rd_q <= tmo_mem[ctl.rd_idx];
		if (ctl.wr_load)
			tmo_mem[ctl.wr_idx] <= ctl.load_val;
	end

	always_ff @(posedge clk) begin
		rem_rd_q <= rem_mem[ctl.rd_idx];
		if (ctl.wr_load)
			rem_mem[ctl.wr_idx] <= ctl.load_val;
		else if (ctl.wr_dec)
			rem_mem[ctl.wr_idx] <= rem_dec;
		else if (ctl.wr_reload)
			rem_mem[ctl.wr_idx] <= tmo_rd_q;
	end

endmodule

// File: rtl/mcwd_seq.sv
module mcwd_seq
	import mcwd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic [CH_BITS-1:0] channel,
	input  logic [TMO_BITS-1:0] timeout,
	output logic               strobe,
	output logic [CH_BITS-1:0] report_channel,
	output logic               report_kind,
	output logic               last,
	output tbl_ctl_t           ctl,
	input  tbl_sts_t           sts
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FEED,
		S_FLUSH
	} state_t;

	state_t             state_q;
	idx_t               cnt_q;
	logic [CH_BITS-1:0] ch_q;
	logic               intab_q;
	logic               pend_q;
	idx_t               pend_idx_q;
	logic               strobe_q;
	logic [CH_BITS-1:0] rch_q;
	logic               rkind_q;
	logic               rlast_q;

	logic    accept;
	logic    in_table;
	action_t act;
	logic    expired;
	logic    scan_end;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign act      = action_t'(action);
	assign in_table = (32'(channel) < CHANNELS);
	assign expired  = sts.vld && sts.rem_zero;
	assign scan_end = (cnt_q == idx_t'(SCAN_N - 1));

	assign strobe         = strobe_q;
	assign report_channel = rch_q;
	assign report_kind    = rkind_q;
	assign last           = rlast_q;

	always_comb begin
		ctl          = '0;
		ctl.load_val = to_cnt(timeout);
		unique case (state_q)
			S_IDLE: begin
				ctl.rd_idx = (act == ACT_TICK) ? '0 : to_idx(channel);
				ctl.wr_idx = to_idx(channel);
				if (accept && in_table) begin
					ctl.set_vld = (act == ACT_REG);
					ctl.wr_load = (act == ACT_REG);
					ctl.clr_vld = (act == ACT_UNREG);
				end
			end
			S_SCAN: begin
				ctl.rd_idx = cnt_q + idx_t'(1);
				ctl.wr_idx = cnt_q;
				ctl.wr_dec = sts.vld && !sts.rem_zero;
			end
			S_FEED: begin
				ctl.wr_idx    = to_idx(ch_q);
				ctl.wr_reload = intab_q && sts.vld;
			end
			S_FLUSH: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			ch_q       <= '0;
			intab_q    <= 1'b0;
			pend_q     <= 1'b0;
			pend_idx_q <= '0;
			strobe_q   <= 1'b0;
			rch_q      <= '0;
			rkind_q    <= KIND_EXPIRED;
			rlast_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ch_q    <= channel;
						intab_q <= in_table;
						cnt_q   <= '0;
						pend_q  <= 1'b0;
						if (act == ACT_TICK)
							state_q <= S_SCAN;
						else if (act == ACT_FEED)
							state_q <= S_FEED;
					end
				end
				S_SCAN: begin
					// an expiry is held back one find so the final one can carry last
					if (expired) begin
						if (pend_q) begin
							strobe_q <= 1'b1;
							rch_q    <= to_ch(pend_idx_q);
							rkind_q  <= KIND_EXPIRED;
							rlast_q  <= 1'b0;
						end
						pend_q     <= 1'b1;
						pend_idx_q <= cnt_q;
					end
					cnt_q <= cnt_q + idx_t'(1);
					if (scan_end)
						state_q <= S_FLUSH;
				end
				S_FLUSH: begin
					if (pend_q) begin
						strobe_q <= 1'b1;
						rch_q    <= to_ch(pend_idx_q);
						rkind_q  <= KIND_EXPIRED;
						rlast_q  <= 1'b1;
					end
					pend_q  <= 1'b0;
					state_q <= S_IDLE;
				end
				S_FEED: begin
					if (!(intab_q && sts.vld)) begin
						strobe_q <= 1'b1;
						rch_q    <= ch_q;
						rkind_q  <= KIND_NOREG;
						rlast_q  <= 1'b1;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_noreg_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && rkind_q == KIND_NOREG) |-> rlast_q)
		else $error("feed report without last");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (cnt_q <= idx_t'(SCAN_N - 1)))
		else $error("scan index out of range");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && act == ACT_TICK) |=> (busy && cnt_q == '0))
		else $error("tick did not start a scan");

	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH) |=> !pend_q)
		else $error("pending expiry left after scan");

endmodule

// File: rtl/multi_channel_watchdog_top.sv
// Channel   Handshake                 Fields
// command   start / busy              action, channel, timeout
// report    strobe (one cycle)        report_channel, report_kind, last
//
// Register and unregister finish in the accept cycle; busy stays low.
// Feed: table read, then reload or not-registered report.
// Tick: min(CHANNELS,16) channels scanned, one channel per cycle through the shared
// decrement/zero-test unit; the count memory is read one entry ahead of the write.
// arst_n clears the valid bits and the sequencer; timeout and count memories
// are not cleared. Reports cannot be held off: each strobe lasts one cycle.
module multi_channel_watchdog_top
	import mcwd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          action,
	input  logic [CH_BITS-1:0]  channel,
	input  logic [TMO_BITS-1:0] timeout,
	output logic                strobe,
	output logic [CH_BITS-1:0]  report_channel,
	output logic                report_kind,
	output logic                last
);

	tbl_ctl_t ctl;
	tbl_sts_t sts;

	// command decode, scan sequencing and report registers
	mcwd_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.channel        (channel),
		.timeout        (timeout),
		.strobe         (strobe),
		.report_channel (report_channel),
		.report_kind    (report_kind),
		.last           (last),
		.ctl            (ctl),
		.sts            (sts)
	);

	// valid bits, timeout and count stores, decrement unit
	mcwd_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts)
	);

endmodule
